// ===== rtl/simc_pkg.sv =====
package simc_pkg;

  localparam int OPERAND_DEPTH = 8;
  localparam int SUM_DEPTH     = 16;
  localparam int INDEX_BITS    = 16;
  localparam int VALUE_BITS    = 32;
  localparam int CMD_DEPTH     = 2;
  localparam int MAX_RESULTS   = 5;

  localparam int OP_PTR_W   = $clog2(OPERAND_DEPTH);
  localparam int OP_FILL_W  = $clog2(OPERAND_DEPTH + 1);
  localparam int SUM_PTR_W  = $clog2(SUM_DEPTH);
  localparam int SUM_FILL_W = $clog2(SUM_DEPTH + 1);
  localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
  localparam int RES_CNT_W  = $clog2(MAX_RESULTS + 1);

  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_BOTTOM_ROW = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_COL  = 1'd1;

  localparam logic [2:0] KIND_A      = 3'd0;
  localparam logic [2:0] KIND_B      = 3'd1;
  localparam logic [2:0] KIND_SUM    = 3'd2;
  localparam logic [2:0] KIND_DONE_A = 3'd3;
  localparam logic [2:0] KIND_DONE_B = 3'd4;
  localparam logic [2:0] KIND_TICK   = 3'd5;

  typedef enum logic [2:0] {
    OP_PUSH_A,
    OP_PUSH_B,
    OP_PUSH_SUM,
    OP_DONE_A,
    OP_DONE_B,
    OP_TICK
  } op_t;

  typedef enum logic [2:0] {
    RK_A_DOWN     = 3'd0,
    RK_B_RIGHT    = 3'd1,
    RK_PSUM       = 3'd2,
    RK_DONE_DOWN  = 3'd3,
    RK_DONE_RIGHT = 3'd4,
    RK_OVERFLOW   = 3'd5
  } rkind_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] val;
    logic [INDEX_BITS-1:0] i1;
    logic [INDEX_BITS-1:0] i2;
  } item_t;

  typedef struct packed {
    logic down_busy;
    logic right_busy;
    logic psum_busy;
    logic dtok_busy;
    logic rtok_busy;
    logic top_pending;
    logic left_pending;
  } links_t;

  typedef struct packed {
    op_t    op;
    item_t  item;
    links_t links;
  } cmd_t;

  typedef struct packed {
    rkind_t kind;
    item_t  item;
  } result_t;

endpackage

// ===== rtl/simc_front.sv =====
module simc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          kind,
  input  simc_pkg::item_t     item,
  input  simc_pkg::links_t    links,
  output logic                cmd_valid,
  output simc_pkg::cmd_t      cmd,
  input  logic                cmd_take
);

  simc_pkg::cmd_t                       cmd_q [simc_pkg::CMD_DEPTH];
  logic [simc_pkg::CMD_PTR_W-1:0]       wr_ptr;
  logic [simc_pkg::CMD_PTR_W-1:0]       rd_ptr;
  logic [simc_pkg::CMD_CNT_W-1:0]       count;
  logic                                 known;
  logic                                 enq;
  logic                                 deq;
  simc_pkg::op_t                        op;

  always_comb begin
    known = 1'b1;
    op    = simc_pkg::OP_TICK;
    unique case (kind)
      simc_pkg::KIND_A:      op = simc_pkg::OP_PUSH_A;
      simc_pkg::KIND_B:      op = simc_pkg::OP_PUSH_B;
      simc_pkg::KIND_SUM:    op = simc_pkg::OP_PUSH_SUM;
      simc_pkg::KIND_DONE_A: op = simc_pkg::OP_DONE_A;
      simc_pkg::KIND_DONE_B: op = simc_pkg::OP_DONE_B;
      simc_pkg::KIND_TICK:   op = simc_pkg::OP_TICK;
      default:               known = 1'b0;
    endcase
  end

  assign full      = (count == simc_pkg::CMD_CNT_W'(simc_pkg::CMD_DEPTH));
  assign enq       = push && !full && known;
  assign cmd_valid = (count != '0);
  assign deq       = cmd_valid && cmd_take;
  assign cmd       = cmd_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      cmd_q[wr_ptr] <= '{op: op, item: item, links: links};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == simc_pkg::CMD_PTR_W'(simc_pkg::CMD_DEPTH - 1)) ? '0 :
                  wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == simc_pkg::CMD_PTR_W'(simc_pkg::CMD_DEPTH - 1)) ? '0 :
                  rd_ptr + 1'b1;
      end
      count <= count + simc_pkg::CMD_CNT_W'(enq) - simc_pkg::CMD_CNT_W'(deq);
    end
  end

endmodule

// ===== rtl/simc_back.sv =====
module simc_back (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cmd_valid,
  input  simc_pkg::cmd_t                                cmd,
  input  logic                                          bottom_row,
  input  logic                                          right_col,
  input  logic                                          out_free,
  output logic                                          take,
  output simc_pkg::result_t [simc_pkg::MAX_RESULTS-1:0] bundle,
  output logic [simc_pkg::RES_CNT_W-1:0]                bundle_n
);

  simc_pkg::item_t a_mem   [simc_pkg::OPERAND_DEPTH];
  simc_pkg::item_t b_mem   [simc_pkg::OPERAND_DEPTH];
  simc_pkg::item_t sum_mem [simc_pkg::SUM_DEPTH];

  logic [simc_pkg::OP_PTR_W-1:0]   a_head, a_tail, b_head, b_tail;
  logic [simc_pkg::OP_FILL_W-1:0]  a_fill, b_fill;
  logic [simc_pkg::SUM_PTR_W-1:0]  sum_head, sum_tail;
  logic [simc_pkg::SUM_FILL_W-1:0] sum_fill;
  logic a_done, b_done, a_sent, b_sent;

  simc_pkg::item_t a_top, b_top, sum_top, prod, psum_item;
  logic [simc_pkg::VALUE_BITS-1:0] prod_val;
  logic is_tick, can_a, can_b, a_nz, b_nz, a_full, b_full, sum_full;
  logic pop_a, pop_b, have_prod, tok_a, tok_b;
  logic push_a, push_b, push_sum_in, ovf_in;
  logic push_prod, pop_sum, emit_psum, emit_ovf, sum_push;
  logic [simc_pkg::RES_CNT_W-1:0] nb;
  simc_pkg::links_t lk;

  assign take     = cmd_valid && out_free;
  assign lk       = cmd.links;
  assign is_tick  = (cmd.op == simc_pkg::OP_TICK);
  assign a_top    = a_mem[a_head];
  assign b_top    = b_mem[b_head];
  assign sum_top  = sum_mem[sum_head];
  assign a_nz     = (a_fill != '0);
  assign b_nz     = (b_fill != '0);
  assign a_full   = (a_fill == simc_pkg::OP_FILL_W'(simc_pkg::OPERAND_DEPTH));
  assign b_full   = (b_fill == simc_pkg::OP_FILL_W'(simc_pkg::OPERAND_DEPTH));
  assign sum_full = (sum_fill == simc_pkg::SUM_FILL_W'(simc_pkg::SUM_DEPTH));
  assign can_a    = bottom_row || !lk.down_busy;
  assign can_b    = right_col || !lk.right_busy;
  assign prod_val = a_top.val * b_top.val;
  assign prod     = '{val: prod_val, i1: a_top.i1, i2: b_top.i2};

  assign push_a      = (cmd.op == simc_pkg::OP_PUSH_A) && !a_full;
  assign push_b      = (cmd.op == simc_pkg::OP_PUSH_B) && !b_full;
  assign push_sum_in = (cmd.op == simc_pkg::OP_PUSH_SUM) && !sum_full;
  assign ovf_in      = ((cmd.op == simc_pkg::OP_PUSH_A) && a_full) ||
                       ((cmd.op == simc_pkg::OP_PUSH_B) && b_full) ||
                       ((cmd.op == simc_pkg::OP_PUSH_SUM) && sum_full);

  always_comb begin
    pop_a     = 1'b0;
    pop_b     = 1'b0;
    have_prod = 1'b0;
    if (is_tick) begin
      if (a_nz && b_nz) begin
        if (a_top.i2 == b_top.i1) begin
          if (can_a && can_b) begin
            pop_a     = 1'b1;
            pop_b     = 1'b1;
            have_prod = 1'b1;
          end
        end else if (a_top.i2 < b_top.i1) begin
          pop_a = can_a;
        end else begin
          pop_b = can_b;
        end
      end else if (b_nz) begin
        pop_b = a_done && !lk.top_pending && can_b;
      end else if (a_nz) begin
        pop_a = b_done && !lk.left_pending && can_a;
      end
    end
  end

  assign tok_a = is_tick && a_done && (a_fill == simc_pkg::OP_FILL_W'(pop_a)) &&
                 !lk.top_pending && !a_sent && !bottom_row && !lk.dtok_busy;
  assign tok_b = is_tick && b_done && (b_fill == simc_pkg::OP_FILL_W'(pop_b)) &&
                 !lk.left_pending && !b_sent && !right_col && !lk.rtok_busy;

  always_comb begin
    push_prod = 1'b0;
    pop_sum   = 1'b0;
    emit_psum = 1'b0;
    emit_ovf  = 1'b0;
    psum_item = sum_top;
    if (have_prod) begin
      if (sum_full) begin
        if (!lk.psum_busy) begin
          emit_psum = 1'b1;
          pop_sum   = 1'b1;
          push_prod = 1'b1;
        end else begin
          emit_ovf = 1'b1;
        end
      end else begin
        push_prod = 1'b1;
        if (!lk.psum_busy) begin
          emit_psum = 1'b1;
          pop_sum   = 1'b1;
          psum_item = (sum_fill == '0) ? prod : sum_top;
        end
      end
    end else if (is_tick && !lk.psum_busy && (sum_fill != '0)) begin
      emit_psum = 1'b1;
      pop_sum   = 1'b1;
    end
  end

  assign sum_push = push_sum_in || push_prod;

  always_comb begin
    bundle = '0;
    nb     = '0;
    if (ovf_in) begin
      bundle[nb] = '{kind: simc_pkg::RK_OVERFLOW, item: cmd.item};
      nb = nb + 1'b1;
    end
    if (pop_a && !bottom_row) begin
      bundle[nb] = '{kind: simc_pkg::RK_A_DOWN, item: a_top};
      nb = nb + 1'b1;
    end
    if (pop_b && !right_col) begin
      bundle[nb] = '{kind: simc_pkg::RK_B_RIGHT, item: b_top};
      nb = nb + 1'b1;
    end
    if (tok_a) begin
      bundle[nb] = '{kind: simc_pkg::RK_DONE_DOWN, item: '0};
      nb = nb + 1'b1;
    end
    if (tok_b) begin
      bundle[nb] = '{kind: simc_pkg::RK_DONE_RIGHT, item: '0};
      nb = nb + 1'b1;
    end
    if (emit_psum) begin
      bundle[nb] = '{kind: simc_pkg::RK_PSUM, item: psum_item};
      nb = nb + 1'b1;
    end else if (emit_ovf) begin
      bundle[nb] = '{kind: simc_pkg::RK_OVERFLOW, item: prod};
      nb = nb + 1'b1;
    end
    bundle_n = nb;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (push_a) begin
        a_mem[a_tail] <= cmd.item;
      end
      if (push_b) begin
        b_mem[b_tail] <= cmd.item;
      end
      if (sum_push) begin
        sum_mem[sum_tail] <= push_prod ? prod : cmd.item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_head   <= '0;
      a_tail   <= '0;
      a_fill   <= '0;
      b_head   <= '0;
      b_tail   <= '0;
      b_fill   <= '0;
      sum_head <= '0;
      sum_tail <= '0;
      sum_fill <= '0;
      a_done   <= 1'b0;
      b_done   <= 1'b0;
      a_sent   <= 1'b0;
      b_sent   <= 1'b0;
    end else if (take) begin
      if (push_a) begin
        a_tail <= (a_tail == simc_pkg::OP_PTR_W'(simc_pkg::OPERAND_DEPTH - 1)) ? '0 :
                  a_tail + 1'b1;
      end
      if (pop_a) begin
        a_head <= (a_head == simc_pkg::OP_PTR_W'(simc_pkg::OPERAND_DEPTH - 1)) ? '0 :
                  a_head + 1'b1;
      end
      a_fill <= a_fill + simc_pkg::OP_FILL_W'(push_a) - simc_pkg::OP_FILL_W'(pop_a);
      if (push_b) begin
        b_tail <= (b_tail == simc_pkg::OP_PTR_W'(simc_pkg::OPERAND_DEPTH - 1)) ? '0 :
                  b_tail + 1'b1;
      end
      if (pop_b) begin
        b_head <= (b_head == simc_pkg::OP_PTR_W'(simc_pkg::OPERAND_DEPTH - 1)) ? '0 :
                  b_head + 1'b1;
      end
      b_fill <= b_fill + simc_pkg::OP_FILL_W'(push_b) - simc_pkg::OP_FILL_W'(pop_b);
      if (sum_push) begin
        sum_tail <= (sum_tail == simc_pkg::SUM_PTR_W'(simc_pkg::SUM_DEPTH - 1)) ? '0 :
                    sum_tail + 1'b1;
      end
      if (pop_sum) begin
        sum_head <= (sum_head == simc_pkg::SUM_PTR_W'(simc_pkg::SUM_DEPTH - 1)) ? '0 :
                    sum_head + 1'b1;
      end
      sum_fill <= sum_fill + simc_pkg::SUM_FILL_W'(sum_push) -
                  simc_pkg::SUM_FILL_W'(pop_sum);
      if (cmd.op == simc_pkg::OP_DONE_A) begin
        a_done <= 1'b1;
      end
      if (cmd.op == simc_pkg::OP_DONE_B) begin
        b_done <= 1'b1;
      end
      if (tok_a) begin
        a_sent <= 1'b1;
      end
      if (tok_b) begin
        b_sent <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/simc_out.sv =====
module simc_out (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          load,
  input  simc_pkg::result_t [simc_pkg::MAX_RESULTS-1:0] bundle,
  input  logic [simc_pkg::RES_CNT_W-1:0]                bundle_n,
  input  logic                                          pop,
  output logic                                          free,
  output logic                                          empty,
  output simc_pkg::result_t                             head,
  output logic                                          last
);

  simc_pkg::result_t [simc_pkg::MAX_RESULTS-1:0] slots;
  logic [simc_pkg::RES_CNT_W-1:0]                cnt;
  logic                                          advance;

  assign empty   = (cnt == '0);
  assign advance = pop && !empty;
  assign last    = (cnt == simc_pkg::RES_CNT_W'(1));
  assign free    = empty || (last && pop);
  assign head    = slots[0];

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= bundle;
    end else if (advance) begin
      for (int i = 0; i < simc_pkg::MAX_RESULTS - 1; i++) begin
        slots[i] <= slots[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= bundle_n;
    end else if (advance) begin
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ===== rtl/sparse_index_match_multiply_cell_top.sv =====
// channel     | handshake             | payload
// ------------+-----------------------+------------------------------------------------
// request in  | push / full           | kind, value, first_index, second_index, link bits
// result out  | empty / pop           | result_kind, out_value, out_first_index,
//             |                       | out_second_index, last
// config      | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// A request enters a two-entry command queue; the back end executes one command per cycle
// while the result buffer is free. A tick yields up to five results, which leave one per cycle
// through the result buffer while pop is high and hold the back end until the last is popped.
// rst clears queue fill levels, stream flags and config; queue contents are not cleared.
// full rises when the command queue is full; the back end waits until the result buffer
// is empty or its last result is being popped.
module sparse_index_match_multiply_cell_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [2:0]                           kind,
  input  logic signed [simc_pkg::VALUE_BITS-1:0] value,
  input  logic [simc_pkg::INDEX_BITS-1:0]      first_index,
  input  logic [simc_pkg::INDEX_BITS-1:0]      second_index,
  input  logic                                 down_busy,
  input  logic                                 right_busy,
  input  logic                                 psum_busy,
  input  logic                                 down_token_busy,
  input  logic                                 right_token_busy,
  input  logic                                 top_pending,
  input  logic                                 left_pending,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [2:0]                           result_kind,
  output logic signed [simc_pkg::VALUE_BITS-1:0] out_value,
  output logic [simc_pkg::INDEX_BITS-1:0]      out_first_index,
  output logic [simc_pkg::INDEX_BITS-1:0]      out_second_index,
  output logic                                 last,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [simc_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic                                          on_bottom_row;
  logic                                          on_right_col;
  logic                                          cfg_wr;
  logic [simc_pkg::REG_IDX_W-1:0]                reg_idx;
  simc_pkg::item_t                               in_item;
  simc_pkg::links_t                              in_links;
  logic                                          cmd_valid;
  simc_pkg::cmd_t                                cmd;
  logic                                          take;
  logic                                          out_free;
  simc_pkg::result_t [simc_pkg::MAX_RESULTS-1:0] bundle;
  logic [simc_pkg::RES_CNT_W-1:0]                bundle_n;
  simc_pkg::result_t                             head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[simc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      on_bottom_row <= 1'b0;
      on_right_col  <= 1'b0;
    end else if (cfg_wr) begin
      if (reg_idx == simc_pkg::REG_BOTTOM_ROW) begin
        on_bottom_row <= pwdata[0];
      end
      if (reg_idx == simc_pkg::REG_RIGHT_COL) begin
        on_right_col <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      simc_pkg::REG_BOTTOM_ROW: prdata[0] = on_bottom_row;
      simc_pkg::REG_RIGHT_COL:  prdata[0] = on_right_col;
      default:                  prdata    = '0;
    endcase
  end

  assign in_item  = '{val: value, i1: first_index, i2: second_index};
  assign in_links = '{down_busy: down_busy, right_busy: right_busy, psum_busy: psum_busy,
                      dtok_busy: down_token_busy, rtok_busy: right_token_busy,
                      top_pending: top_pending, left_pending: left_pending};

  simc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .item      (in_item),
    .links     (in_links),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (take)
  );

  simc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .bottom_row (on_bottom_row),
    .right_col  (on_right_col),
    .out_free   (out_free),
    .take       (take),
    .bundle     (bundle),
    .bundle_n   (bundle_n)
  );

  simc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .bundle   (bundle),
    .bundle_n (bundle_n),
    .pop      (pop),
    .free     (out_free),
    .empty    (empty),
    .head     (head),
    .last     (last)
  );

  assign result_kind      = head.kind;
  assign out_value        = head.item.val;
  assign out_first_index  = head.item.i1;
  assign out_second_index = head.item.i2;

  a_full_means_pending: assert property (@(posedge clk) disable iff (rst)
    full |-> cmd_valid)
    else $error("command queue full with nothing pending");

  a_bundle_continues: assert property (@(posedge clk) disable iff (rst)
    pop && !empty && !last |=> !empty)
    else $error("result burst cut short");

  a_cfg_row_written: assert property (@(posedge clk) disable iff (rst)
    !rst && cfg_wr && (reg_idx == simc_pkg::REG_BOTTOM_ROW) |=>
      on_bottom_row == $past(pwdata[0]))
    else $error("bottom-row register not written");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  localparam logic [6:0] LNK_NONE  = 7'b0000000;
  localparam logic [6:0] LNK_DOWN  = 7'b1000000;
  localparam logic [6:0] LNK_RIGHT = 7'b0100000;
  localparam logic [6:0] LNK_PSUM  = 7'b0010000;
  localparam logic [6:0] LNK_DTOK  = 7'b0001000;
  localparam logic [6:0] LNK_RTOK  = 7'b0000100;
  localparam logic [6:0] LNK_TOP   = 7'b0000010;
  localparam logic [6:0] LNK_LEFT  = 7'b0000001;
  localparam logic [6:0] LNK_ALL   = 7'b1111111;

  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 5000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [15:0] fi;
    logic [15:0] si;
    logic [6:0]  lnk;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [15:0] fi;
    logic [15:0] si;
    logic        last;
  } res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  kind = '0;
  logic signed [simc_pkg::VALUE_BITS-1:0] value = '0;
  logic [simc_pkg::INDEX_BITS-1:0] first_index = '0;
  logic [simc_pkg::INDEX_BITS-1:0] second_index = '0;
  logic        down_busy = 1'b0;
  logic        right_busy = 1'b0;
  logic        psum_busy = 1'b0;
  logic        down_token_busy = 1'b0;
  logic        right_token_busy = 1'b0;
  logic        top_pending = 1'b0;
  logic        left_pending = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  result_kind;
  logic signed [simc_pkg::VALUE_BITS-1:0] out_value;
  logic [simc_pkg::INDEX_BITS-1:0] out_first_index;
  logic [simc_pkg::INDEX_BITS-1:0] out_second_index;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [simc_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sparse_index_match_multiply_cell_top u_top (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .kind(kind), .value(value), .first_index(first_index), .second_index(second_index),
    .down_busy(down_busy), .right_busy(right_busy), .psum_busy(psum_busy),
    .down_token_busy(down_token_busy), .right_token_busy(right_token_busy),
    .top_pending(top_pending), .left_pending(left_pending),
    .empty(empty), .pop(pop),
    .result_kind(result_kind), .out_value(out_value),
    .out_first_index(out_first_index), .out_second_index(out_second_index), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  req_t pending_requests[$];
  res_t awaited_results[$];
  res_t step_out[$];
  req_t cur_req;
  res_t seen;
  int   send_idle = 0;
  int   recv_stall = 0;
  int   errors = 0;
  int   n_added = 0;
  int   quiet_cycles = 0;

  simc_pkg::item_t a_q[$];
  simc_pkg::item_t b_q[$];
  simc_pkg::item_t s_q[$];
  bit    a_done, b_done, a_tok, b_tok;
  bit    cfg_bottom, cfg_right;

  function automatic void log_error(string msg);
    if (errors < 10) $display("%s", msg);
    errors++;
  endfunction

  function automatic void note(logic [2:0] k, simc_pkg::item_t it);
    res_t e;
    e.kind = k;
    e.value = it.val;
    e.fi = it.i1;
    e.si = it.i2;
    e.last = 1'b0;
    step_out.push_back(e);
  endfunction

  task automatic predict_request(input req_t r);
    simc_pkg::item_t it, fa, fb, prod, nil;
    bit can_a, can_b, have_prod, sent_sum;
    res_t e;
    step_out.delete();
    nil = '0;
    it.val = r.value;
    it.i1 = r.fi;
    it.i2 = r.si;
    case (r.kind)
      simc_pkg::KIND_A: begin
        if (a_q.size() >= simc_pkg::OPERAND_DEPTH) note(simc_pkg::RK_OVERFLOW, it);
        else a_q.push_back(it);
      end
      simc_pkg::KIND_B: begin
        if (b_q.size() >= simc_pkg::OPERAND_DEPTH) note(simc_pkg::RK_OVERFLOW, it);
        else b_q.push_back(it);
      end
      simc_pkg::KIND_SUM: begin
        if (s_q.size() >= simc_pkg::SUM_DEPTH) note(simc_pkg::RK_OVERFLOW, it);
        else s_q.push_back(it);
      end
      simc_pkg::KIND_DONE_A: a_done = 1'b1;
      simc_pkg::KIND_DONE_B: b_done = 1'b1;
      simc_pkg::KIND_TICK: begin
        can_a = cfg_bottom || !r.lnk[6];
        can_b = cfg_right || !r.lnk[5];
        have_prod = 1'b0;
        sent_sum = 1'b0;
        prod = '0;
        if (a_q.size() > 0 && b_q.size() > 0) begin
          fa = a_q[0];
          fb = b_q[0];
          if (fa.i2 == fb.i1) begin
            if (can_a && can_b) begin
              prod.val = fa.val * fb.val;
              prod.i1 = fa.i1;
              prod.i2 = fb.i2;
              have_prod = 1'b1;
              if (!cfg_bottom) note(simc_pkg::RK_A_DOWN, fa);
              if (!cfg_right) note(simc_pkg::RK_B_RIGHT, fb);
              fa = a_q.pop_front();
              fb = b_q.pop_front();
            end
          end else if (fa.i2 < fb.i1) begin
            if (can_a) begin
              if (!cfg_bottom) note(simc_pkg::RK_A_DOWN, fa);
              fa = a_q.pop_front();
            end
          end else if (can_b) begin
            if (!cfg_right) note(simc_pkg::RK_B_RIGHT, fb);
            fb = b_q.pop_front();
          end
        end else if (b_q.size() > 0) begin
          if (a_done && !r.lnk[1] && can_b) begin
            fb = b_q.pop_front();
            if (!cfg_right) note(simc_pkg::RK_B_RIGHT, fb);
          end
        end else if (a_q.size() > 0) begin
          if (b_done && !r.lnk[0] && can_a) begin
            fa = a_q.pop_front();
            if (!cfg_bottom) note(simc_pkg::RK_A_DOWN, fa);
          end
        end
        if (a_done && a_q.size() == 0 && !r.lnk[1] && !a_tok && !cfg_bottom &&
            !r.lnk[3]) begin
          note(simc_pkg::RK_DONE_DOWN, nil);
          a_tok = 1'b1;
        end
        if (b_done && b_q.size() == 0 && !r.lnk[0] && !b_tok && !cfg_right &&
            !r.lnk[2]) begin
          note(simc_pkg::RK_DONE_RIGHT, nil);
          b_tok = 1'b1;
        end
        if (have_prod) begin
          if (s_q.size() < simc_pkg::SUM_DEPTH) begin
            s_q.push_back(prod);
          end else if (!r.lnk[4]) begin
            note(simc_pkg::RK_PSUM, s_q.pop_front());
            s_q.push_back(prod);
            sent_sum = 1'b1;
          end else begin
            note(simc_pkg::RK_OVERFLOW, prod);
            sent_sum = 1'b1;
          end
        end
        if (!sent_sum && !r.lnk[4] && s_q.size() > 0)
          note(simc_pkg::RK_PSUM, s_q.pop_front());
      end
      default: ;
    endcase
    foreach (step_out[i]) begin
      e = step_out[i];
      e.last = (i == step_out.size() - 1);
      awaited_results.push_back(e);
    end
  endtask

  // driver: present the next request, hold it while full
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) predict_request(cur_req);
      if (!push || !full) begin
        if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          cur_req = pending_requests.pop_front();
          kind <= cur_req.kind;
          value <= cur_req.value;
          first_index <= cur_req.fi;
          second_index <= cur_req.si;
          down_busy <= cur_req.lnk[6];
          right_busy <= cur_req.lnk[5];
          psum_busy <= cur_req.lnk[4];
          down_token_busy <= cur_req.lnk[3];
          right_token_busy <= cur_req.lnk[2];
          top_pending <= cur_req.lnk[1];
          left_pending <= cur_req.lnk[0];
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each popped result with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          log_error($sformatf("unexpected result: kind %0d value %h idx %h/%h last %b",
                              result_kind, out_value, out_first_index, out_second_index,
                              last));
        end else begin
          seen = awaited_results.pop_front();
          if (result_kind !== seen.kind || out_value !== seen.value ||
              out_first_index !== seen.fi || out_second_index !== seen.si ||
              last !== seen.last)
            log_error($sformatf({"mismatch: expected kind %0d value %h idx %h/%h last %b,",
                                 " got kind %0d value %h idx %h/%h last %b"},
                                seen.kind, seen.value, seen.fi, seen.si, seen.last,
                                result_kind, out_value, out_first_index, out_second_index,
                                last));
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable && pwrite && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic reg_write(input logic [simc_pkg::REG_IDX_W-1:0] idx, input bit bitval);
    logic [31:0] data;
    data = $urandom;
    data[0] = bitval;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == simc_pkg::REG_BOTTOM_ROW) cfg_bottom = bitval;
    else cfg_right = bitval;
  endtask

  task automatic set_edge_position(input bit row, input bit col);
    reg_write(simc_pkg::REG_BOTTOM_ROW, row);
    reg_write(simc_pkg::REG_RIGHT_COL, col);
  endtask

  // sample after the edge so the driver's updates of this edge are seen
  task automatic settle();
    @(negedge clk);
    while (pending_requests.size() != 0 || push || awaited_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic req_t make_req(logic [2:0] k, logic [31:0] v, logic [15:0] f,
                                    logic [15:0] s);
    req_t r;
    r.kind = k;
    r.value = v;
    r.fi = f;
    r.si = s;
    r.lnk = LNK_NONE;
    return r;
  endfunction

  function automatic req_t make_tick(logic [6:0] lnk);
    req_t r;
    r = make_req(simc_pkg::KIND_TICK, $urandom, 16'($urandom), 16'($urandom));
    r.lnk = lnk;
    return r;
  endfunction

  function automatic logic [6:0] rand_links(int busy_pct);
    logic [6:0] l;
    for (int i = 0; i < 7; i++) l[i] = ($urandom_range(0, 99) < busy_pct);
    return l;
  endfunction

  task automatic add(input req_t r);
    pending_requests.push_back(r);
    n_added++;
  endtask

  // sorted A and B streams over a shared k range, interleaved with ticks
  task automatic add_stream();
    req_t a_list[$], b_list[$];
    int base, ka, kb, na, nb, pick;
    base = $urandom_range(0, 65400);
    ka = base;
    kb = base;
    na = $urandom_range(1, 5);
    nb = $urandom_range(1, 5);
    for (int i = 0; i < na; i++) begin
      ka += $urandom_range(0, 3);
      a_list.push_back(make_req(simc_pkg::KIND_A, $urandom, 16'($urandom), ka[15:0]));
    end
    for (int i = 0; i < nb; i++) begin
      kb += $urandom_range(0, 3);
      b_list.push_back(make_req(simc_pkg::KIND_B, $urandom, kb[15:0], 16'($urandom)));
    end
    while (a_list.size() > 0 || b_list.size() > 0) begin
      pick = $urandom_range(0, 3);
      if (pick == 0 && a_list.size() > 0) add(a_list.pop_front());
      else if (pick == 1 && b_list.size() > 0) add(b_list.pop_front());
      else if (pick == 2) add(make_tick(rand_links(15)));
      else if (a_list.size() > 0) add(a_list.pop_front());
      else add(b_list.pop_front());
    end
    for (int i = 0; i < na + nb + 2; i++) add(make_tick(rand_links(15)));
  endtask

  task automatic add_noise();
    req_t r;
    r = make_req(3'($urandom_range(0, 7)), $urandom, 16'($urandom), 16'($urandom));
    r.lnk = 7'($urandom);
    add(r);
  endtask

  // fill the sum queue, then land products on it with the link free and busy
  task automatic add_sum_flood();
    logic [15:0] k;
    for (int i = 0; i < simc_pkg::SUM_DEPTH + 1; i++)
      add(make_req(simc_pkg::KIND_SUM, $urandom, 16'($urandom), 16'($urandom)));
    for (int i = 0; i < 2; i++) begin
      k = 16'($urandom);
      add(make_req(simc_pkg::KIND_A, $urandom, 16'($urandom), k));
      add(make_req(simc_pkg::KIND_B, $urandom, k, 16'($urandom)));
      add(make_tick(i == 0 ? LNK_NONE : LNK_PSUM));
    end
    for (int i = 0; i < 3; i++) add(make_tick(rand_links(10)));
  endtask

  task automatic add_a_flood();
    logic [15:0] k;
    k = 16'($urandom_range(0, 60000));
    for (int i = 0; i < simc_pkg::OPERAND_DEPTH + 1; i++)
      add(make_req(simc_pkg::KIND_A, $urandom, 16'($urandom), k + 16'(i)));
    add(make_tick(LNK_NONE));
    for (int i = 0; i < 3; i++)
      add(make_req(simc_pkg::KIND_B, $urandom, k + 16'(i), 16'($urandom)));
    for (int i = 0; i < 6; i++) add(make_tick(rand_links(10)));
  endtask

  task automatic add_random(input int budget);
    int stop_at, pick;
    stop_at = n_added + budget;
    while (n_added < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) add_stream();
      else add_noise();
    end
  endtask

  task automatic add_directed();
    add(make_req(simc_pkg::KIND_A, 32'h7FFF_FFFF, 16'hFFFF, 16'h0000));
    add(make_req(simc_pkg::KIND_B, 32'h8000_0000, 16'h0000, 16'hFFFF));
    add(make_tick(LNK_NONE));
    add(make_req(simc_pkg::KIND_A, 32'hFFFF_FFFF, 16'h0000, 16'h0002));
    add(make_req(simc_pkg::KIND_B, 32'h0000_0005, 16'h0001, 16'h0000));
    add(make_tick(LNK_DOWN));
    add(make_req(simc_pkg::KIND_B, 32'h1234_5678, 16'h0002, 16'h8001));
    add(make_tick(LNK_DOWN));
    add(make_tick(LNK_RIGHT | LNK_PSUM | LNK_DTOK | LNK_RTOK | LNK_TOP | LNK_LEFT));
    add(make_tick(LNK_NONE));
    add(make_req(simc_pkg::KIND_SUM, 32'h8000_0000, 16'hFFFF, 16'hFFFF));
    add(make_tick(LNK_PSUM));
    add(make_req(KIND_SPARE_6, $urandom, 16'($urandom), 16'($urandom)));
    add(make_req(KIND_SPARE_7, $urandom, 16'($urandom), 16'($urandom)));
    add(make_tick(LNK_ALL));
    add(make_tick(LNK_NONE));
  endtask

  task automatic add_finish();
    add(make_req(simc_pkg::KIND_A, $urandom, 16'($urandom), 16'h000A));
    add(make_req(simc_pkg::KIND_DONE_B, $urandom, 16'($urandom), 16'($urandom)));
    add(make_tick(LNK_LEFT));
    add(make_tick(LNK_RTOK));
    add(make_tick(LNK_NONE));
    add(make_req(simc_pkg::KIND_DONE_B, $urandom, 16'($urandom), 16'($urandom)));
    add(make_tick(LNK_NONE));
    add(make_req(simc_pkg::KIND_DONE_A, $urandom, 16'($urandom), 16'($urandom)));
    add(make_tick(LNK_DTOK));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_edge_position(1'b0, 1'b0);
    send_idle = 0;
    recv_stall = 0;
    add_directed();
    settle();

    set_edge_position(1'b1, 1'b0);
    send_idle = 82;
    recv_stall = 0;
    add_sum_flood();
    add_random(5);
    settle();

    set_edge_position(1'b0, 1'b1);
    send_idle = 0;
    recv_stall = 82;
    add_a_flood();
    add_random(4);
    settle();

    set_edge_position(1'b0, 1'b0);
    send_idle = 32;
    recv_stall = 32;
    add_finish();
    add_random(7);
    settle();

    set_edge_position(1'b1, 1'b1);
    send_idle = 0;
    recv_stall = 0;
    add_random(5);
    settle();

    set_edge_position(1'b0, 1'b1);
    send_idle = 0;
    recv_stall = 82;
    add_random(5);
    settle();

    if (errors == 0 && awaited_results.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
